@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key gesture detector checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/kgd_pkg.sv @@
// ----------------------------------------------------------------------------
// kgd_pkg
// Types and constants shared by the key gesture detector modules.
// ----------------------------------------------------------------------------
package kgd_pkg;

	localparam int OP_W       = 2;
	localparam int KEY_CODE_W = 4;
	localparam int TIME_W     = 32;
	localparam int KIND_W     = 3;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int COMBO_KEY_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS   = 3'd0,
		KIND_RELEASE = 3'd1,
		KIND_SHORT   = 3'd2,
		KIND_LONG    = 3'd3,
		KIND_RESET   = 3'd4
	} kind_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO_HOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO_A    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO_B    = 3'd4;

	// Configuration reset values.
	localparam logic [CFG_W-1:0]       RST_SHORT_MAX  = 16'd300;
	localparam logic [CFG_W-1:0]       RST_LONG       = 16'd500;
	localparam logic [CFG_W-1:0]       RST_COMBO_HOLD = 16'd3000;
	localparam logic [COMBO_KEY_W-1:0] RST_COMBO_A    = 4'd0;
	localparam logic [COMBO_KEY_W-1:0] RST_COMBO_B    = 4'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic press;
		logic rel_short;
		logic rel_end;
		logic scan;
		logic combo;
		logic flush;
	} kgd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_press;
		logic is_release;
		logic is_tick;
		logic key_ok;
		logic can_emit;
		logic out_free;
		logic pend_valid;
		logic scan_last;
	} kgd_stat_t;

endpackage

@@ hw/rtl/kgd_if.sv @@
// ----------------------------------------------------------------------------
// kgd_if
// Valid/ready channel interfaces for key items and gesture events.
// ----------------------------------------------------------------------------
interface kgd_req_if import kgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [KEY_CODE_W-1:0] key_code;
	logic [TIME_W-1:0]     time_now;

	modport source (output valid, operation, key_code, time_now, input ready);
	modport sink   (input valid, operation, key_code, time_now, output ready);
endinterface

interface kgd_evt_if import kgd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KEY_CODE_W-1:0] event_key;
	logic [KIND_W-1:0]     event_kind;
	logic                  last_of_run;

	modport source (output valid, event_key, event_kind, last_of_run, input ready);
	modport sink   (input valid, event_key, event_kind, last_of_run, output ready);
endinterface

@@ hw/rtl/key_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// key_gesture_detector
// Turns raw key press, release and tick items into gesture events.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on req (operation, key_code, time_now) and are taken one at a
// time: req.ready is high only while the block is idle. Each item yields zero
// or more events on evt (event_key, event_kind), the final one of an item
// marked by last_of_run. Configuration writes (cfg_we, cfg_idx, cfg_wdata)
// are to be made only while no item is in progress; the block does not enforce this.
// An emitted event is held back in a pending register and moves on to the
// output register when a later event or the final flush pushes it out.
// A tick walks the keys one per cycle unless the sequencer pauses, then checks
// the combo hold.
// When evt stalls, one event waits in the output register and one more is
// held back; the sequencer pauses until the output register drains.
// Reset clears the held and long-press flags, the combo run flag and the event
// valid flags, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module key_gesture_detector import kgd_pkg::*; #(
	parameter int KEY_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	kgd_req_if.sink              req,
	kgd_evt_if.source            evt
);

	kgd_cmd_t  cmd;
	kgd_stat_t stat;
	logic      idle;

	assign req.ready = idle;

	kgd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid),
		.stat   (stat),
		.cmd    (cmd),
		.idle   (idle)
	);

	kgd_dp #(
		.KEY_COUNT (KEY_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.operation   (req.operation),
		.key_code    (req.key_code),
		.time_now    (req.time_now),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (evt.valid),
		.out_ready   (evt.ready),
		.event_key   (evt.event_key),
		.event_kind  (evt.event_kind),
		.last_of_run (evt.last_of_run)
	);

endmodule

@@ hw/rtl/kgd_ctrl.sv @@
// ----------------------------------------------------------------------------
// kgd_ctrl
// Sequencer that steps the datapath through one key item at a time.
// ----------------------------------------------------------------------------
module kgd_ctrl import kgd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  kgd_stat_t stat,
	output kgd_cmd_t  cmd,
	output logic      idle
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PRESS,
		ST_REL_SHORT,
		ST_REL_END,
		ST_SCAN,
		ST_COMBO,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (stat.is_press && stat.key_ok) begin
					state_d = ST_PRESS;
				end else if (stat.is_release && stat.key_ok) begin
					state_d = ST_REL_SHORT;
				end else if (stat.is_tick) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PRESS: begin
				if (stat.can_emit) begin
					cmd.press = 1'b1;
					state_d   = ST_FLUSH;
				end
			end
			ST_REL_SHORT: begin
				if (stat.can_emit) begin
					cmd.rel_short = 1'b1;
					state_d       = ST_REL_END;
				end
			end
			ST_REL_END: begin
				if (stat.can_emit) begin
					cmd.rel_end = 1'b1;
					state_d     = ST_FLUSH;
				end
			end
			ST_SCAN: begin
				if (stat.can_emit) begin
					cmd.scan = 1'b1;
					if (stat.scan_last) begin
						state_d = ST_COMBO;
					end
				end
			end
			ST_COMBO: begin
				if (stat.can_emit) begin
					cmd.combo = 1'b1;
					state_d   = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// The held-back event goes out last, marked as the end of the run.
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule

@@ hw/rtl/kgd_dp.sv @@
// ----------------------------------------------------------------------------
// kgd_dp
// Per-key state, timing compares, configuration and the event output stage.
// ----------------------------------------------------------------------------
module kgd_dp import kgd_pkg::*; #(
	parameter int KEY_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic [OP_W-1:0]       operation,
	input  logic [KEY_CODE_W-1:0] key_code,
	input  logic [TIME_W-1:0]     time_now,
	input  kgd_cmd_t              cmd,
	output kgd_stat_t             stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KEY_CODE_W-1:0] event_key,
	output logic [KIND_W-1:0]     event_kind,
	output logic                  last_of_run
);

	localparam int KEY_W = $clog2(KEY_COUNT);

	// Configuration.
	logic [CFG_W-1:0]       short_max_q;
	logic [CFG_W-1:0]       long_ms_q;
	logic [CFG_W-1:0]       combo_hold_q;
	logic [COMBO_KEY_W-1:0] combo_a_q;
	logic [COMBO_KEY_W-1:0] combo_b_q;

	// Latched item.
	logic [OP_W-1:0]       op_q;
	logic [KEY_CODE_W-1:0] key_q;
	logic [TIME_W-1:0]     now_q;

	// Key state.
	logic [KEY_COUNT-1:0]  held_q;
	logic [KEY_COUNT-1:0]  long_q;
	logic [TIME_W-1:0]     press_time_q [KEY_COUNT];
	logic                  combo_run_q;
	logic [TIME_W-1:0]     combo_start_q;
	logic [KEY_W-1:0]      idx_q;

	// One event held back so that the last one of a run can be marked.
	logic                  pend_v_q;
	logic [KEY_CODE_W-1:0] pend_key_q;
	logic [KIND_W-1:0]     pend_kind_q;

	logic                  out_v_q;
	logic [KEY_CODE_W-1:0] out_key_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic                  out_last_q;

	logic                  key_ok;
	logic [KEY_W-1:0]      kidx;
	logic [KEY_W-1:0]      sel;
	logic [TIME_W-1:0]     hold;
	logic [TIME_W-1:0]     combo_elapsed;
	logic                  held_a;
	logic                  held_b;
	logic                  combo_both;
	logic                  out_free;
	logic                  out_load;
	logic                  emit_v;
	logic [KEY_CODE_W-1:0] emit_key;
	logic [KIND_W-1:0]     emit_kind;

	assign key_ok = ({1'b0, key_q} < (KEY_CODE_W+1)'(KEY_COUNT));
	assign kidx   = key_q[KEY_W-1:0];
	assign sel    = cmd.scan ? idx_q : kidx;
	assign hold   = now_q - press_time_q[sel];
	assign combo_elapsed = now_q - combo_start_q;

	// A combo key beyond the key range never counts as held.
	assign held_a = ({1'b0, combo_a_q} < (COMBO_KEY_W+1)'(KEY_COUNT))
		&& held_q[combo_a_q[KEY_W-1:0]];
	assign held_b = ({1'b0, combo_b_q} < (COMBO_KEY_W+1)'(KEY_COUNT))
		&& held_q[combo_b_q[KEY_W-1:0]];
	assign combo_both = held_a && held_b;

	assign out_free = !out_v_q || out_ready;

	always_comb begin
		emit_v    = 1'b0;
		emit_key  = key_q;
		emit_kind = KIND_PRESS;
		if (cmd.press) begin
			emit_v = 1'b1;
		end else if (cmd.rel_short) begin
			emit_v    = held_q[kidx] && !long_q[kidx] && (hold < TIME_W'(short_max_q));
			emit_kind = KIND_SHORT;
		end else if (cmd.rel_end) begin
			emit_v    = 1'b1;
			emit_kind = KIND_RELEASE;
		end else if (cmd.scan) begin
			emit_v    = held_q[idx_q] && !long_q[idx_q] && (hold >= TIME_W'(long_ms_q));
			emit_key  = KEY_CODE_W'(idx_q);
			emit_kind = KIND_LONG;
		end else if (cmd.combo) begin
			emit_v    = combo_both && combo_run_q
				&& (combo_elapsed >= TIME_W'(combo_hold_q));
			emit_key  = '0;
			emit_kind = KIND_RESET;
		end
	end

	// The controller only emits when the output register can take the pending event.
	assign out_load = (emit_v && pend_v_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_max_q  <= RST_SHORT_MAX;
			long_ms_q    <= RST_LONG;
			combo_hold_q <= RST_COMBO_HOLD;
			combo_a_q    <= RST_COMBO_A;
			combo_b_q    <= RST_COMBO_B;
			held_q       <= '0;
			long_q       <= '0;
			combo_run_q  <= 1'b0;
			idx_q        <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SHORT_MAX:  short_max_q  <= cfg_wdata;
					CFG_LONG:       long_ms_q    <= cfg_wdata;
					CFG_COMBO_HOLD: combo_hold_q <= cfg_wdata;
					CFG_COMBO_A:    combo_a_q    <= cfg_wdata[COMBO_KEY_W-1:0];
					CFG_COMBO_B:    combo_b_q    <= cfg_wdata[COMBO_KEY_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.press) begin
				held_q[kidx] <= 1'b1;
				long_q[kidx] <= 1'b0;
			end
			if (cmd.rel_end) begin
				held_q[kidx] <= 1'b0;
			end
			if (cmd.scan && emit_v) begin
				long_q[idx_q] <= 1'b1;
			end
			if (cmd.combo) begin
				if (!combo_both || emit_v) begin
					combo_run_q <= 1'b0;
				end else begin
					combo_run_q <= 1'b1;
				end
			end
			if (emit_v) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key_code;
			now_q <= time_now;
		end
		if (cmd.press) begin
			press_time_q[kidx] <= now_q;
		end
		if (cmd.combo && combo_both && !combo_run_q) begin
			combo_start_q <= now_q;
		end
		if (emit_v) begin
			pend_key_q  <= emit_key;
			pend_kind_q <= emit_kind;
		end
		if (out_load) begin
			out_key_q  <= pend_key_q;
			out_kind_q <= pend_kind_q;
			out_last_q <= cmd.flush;
		end
	end

	always_comb begin
		stat            = '0;
		stat.is_press   = (op_q == OP_PRESS);
		stat.is_release = (op_q == OP_RELEASE);
		stat.is_tick    = (op_q == OP_TICK);
		stat.key_ok     = key_ok;
		stat.can_emit   = !pend_v_q || out_free;
		stat.out_free   = out_free;
		stat.pend_valid = pend_v_q;
		stat.scan_last  = (idx_q == KEY_W'(KEY_COUNT - 1));
	end

	assign out_valid   = out_v_q;
	assign event_key   = out_key_q;
	assign event_kind  = out_kind_q;
	assign last_of_run = out_last_q;

endmodule

@@ hw/rtl/kgd_checker.sv @@
// ----------------------------------------------------------------------------
// kgd_checker
// Port-level checks on the key gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kgd_checker import kgd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  evt_valid,
	input logic                  evt_ready,
	input logic [KEY_CODE_W-1:0] evt_key,
	input logic [KIND_W-1:0]     evt_kind,
	input logic                  evt_last
);

	// An accepted item keeps the block busy for at least the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// A stalled event keeps its contents.
	`ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable({evt_key, evt_kind, evt_last}))

	// A combo reset concerns no key and always ends the run of its tick.
	`ASSERT_SAME(a_reset_shape, clk, arst_n, evt_valid && evt_kind == KIND_RESET, evt_key == '0 && evt_last)

	// A press is the only event of its item.
	`ASSERT_SAME(a_press_alone, clk, arst_n, evt_valid && evt_kind == KIND_PRESS, evt_last)

endmodule

bind key_gesture_detector kgd_checker u_kgd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_key   (evt.event_key),
	.evt_kind  (evt.event_kind),
	.evt_last  (evt.last_of_run)
);

@@ dv/tb_key_gesture_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_gesture_detector
// Self-checking bench for the key gesture detector. Press, release and tick
// items go in over the request channel. A behavioral predictor queues the
// gesture events that each item should produce, and every event taken from
// the event channel is compared field by field with the oldest one queued.
// The run covers the register extremes and several idle and stall patterns.
// ----------------------------------------------------------------------------

module tb_key_gesture_detector import kgd_pkg::*; ();

	class gesture_scoreboard #(int KEYS = 8);
		localparam int KW = $clog2(KEYS);

		typedef struct packed {
			logic [KEY_CODE_W-1:0] key;
			kind_t                 kind;
			logic                  last;
		} gesture_t;

		bit                    held[KEYS];
		bit [TIME_W-1:0]       press_at[KEYS];
		bit                    long_done[KEYS];
		bit                    combo_on;
		bit [TIME_W-1:0]       combo_t0;

		bit [CFG_W-1:0]        short_max;
		bit [CFG_W-1:0]        long_min;
		bit [CFG_W-1:0]        combo_hold;
		bit [COMBO_KEY_W-1:0]  combo_a;
		bit [COMBO_KEY_W-1:0]  combo_b;

		gesture_t gesture_q[$];
		int errors;
		int checked;
		int n_long;
		int n_reset;

		function new();
			short_max  = RST_SHORT_MAX;
			long_min   = RST_LONG;
			combo_hold = RST_COMBO_HOLD;
			combo_a    = RST_COMBO_A;
			combo_b    = RST_COMBO_B;
			combo_on   = 1'b0;
			combo_t0   = '0;
			for (int i = 0; i < KEYS; i++) begin
				held[i]      = 1'b0;
				press_at[i]  = '0;
				long_done[i] = 1'b0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_SHORT_MAX:  short_max  = val;
				CFG_LONG:       long_min   = val;
				CFG_COMBO_HOLD: combo_hold = val;
				CFG_COMBO_A:    combo_a    = val[COMBO_KEY_W-1:0];
				CFG_COMBO_B:    combo_b    = val[COMBO_KEY_W-1:0];
				default: ;
			endcase
		endfunction

		// A combo key beyond the key range never counts as held.
		function bit held_at(logic [COMBO_KEY_W-1:0] k);
			return (k < KEYS) ? held[k[KW-1:0]] : 1'b0;
		endfunction

		function int pending();
			return gesture_q.size();
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [KEY_CODE_W-1:0] key,
				logic [TIME_W-1:0] now);
			gesture_t run_q[$];
			logic [TIME_W-1:0] held_for;
			logic [KW-1:0] ki;
			ki = key[KW-1:0];
			case (op)
				OP_PRESS: begin
					if (key < KEYS) begin
						held[ki]      = 1'b1;
						press_at[ki]  = now;
						long_done[ki] = 1'b0;
						run_q.push_back('{key: key, kind: KIND_PRESS, last: 1'b0});
					end
				end
				OP_RELEASE: begin
					if (key < KEYS) begin
						if (held[ki]) begin
							held_for = now - press_at[ki];
							if (!long_done[ki] && held_for < short_max)
								run_q.push_back('{key: key, kind: KIND_SHORT, last: 1'b0});
							held[ki] = 1'b0;
						end
						run_q.push_back('{key: key, kind: KIND_RELEASE, last: 1'b0});
					end
				end
				OP_TICK: begin
					for (int i = 0; i < KEYS; i++) begin
						if (held[i] && !long_done[i]) begin
							held_for = now - press_at[i];
							if (held_for >= long_min) begin
								long_done[i] = 1'b1;
								run_q.push_back('{key: i[KEY_CODE_W-1:0], kind: KIND_LONG,
									last: 1'b0});
								n_long++;
							end
						end
					end
					// The first tick that sees the combo held only starts its timer.
					if (held_at(combo_a) && held_at(combo_b)) begin
						held_for = now - combo_t0;
						if (!combo_on) begin
							combo_on = 1'b1;
							combo_t0 = now;
						end else if (held_for >= combo_hold) begin
							run_q.push_back('{key: '0, kind: KIND_RESET, last: 1'b0});
							n_reset++;
							combo_on = 1'b0;
							combo_t0 = '0;
						end
					end else begin
						combo_on = 1'b0;
						combo_t0 = '0;
					end
				end
				default: ;
			endcase
			if (run_q.size() > 0)
				run_q[run_q.size()-1].last = 1'b1;
			foreach (run_q[j])
				gesture_q.push_back(run_q[j]);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_event(logic [KEY_CODE_W-1:0] key, logic [KIND_W-1:0] kind, logic last);
			gesture_t want;
			checked++;
			if (gesture_q.size() == 0) begin
				report_mismatch($sformatf("event key %0d kind %0d with nothing pending",
					key, kind));
				return;
			end
			want = gesture_q.pop_front();
			if (key !== want.key)
				report_mismatch($sformatf("event_key %0d, predicted %0d (%s)",
					key, want.key, want.kind.name()));
			if (kind !== want.kind)
				report_mismatch($sformatf("event_kind %0d, predicted %s",
					kind, want.kind.name()));
			if (last !== want.last)
				report_mismatch($sformatf("last_of_run %0b, predicted %0b (%s)",
					last, want.last, want.kind.name()));
		endtask
	endclass

	localparam int NUM_KEYS     = 8;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = NUM_KEYS + 8;

	// Operation code that the block must ignore.
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	kgd_req_if req();
	kgd_evt_if evt();

	key_gesture_detector #(.KEY_COUNT(NUM_KEYS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.evt       (evt)
	);

	gesture_scoreboard #(NUM_KEYS) sb;

	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_off_req;
	int              hold_left;
	int              items_sent;
	int              cycles;
	int              step_max;
	logic [TIME_W-1:0] now_ms;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL key_gesture_detector");
		$finish;
	end

	// Event receiver: checks every taken event and decides ready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && evt.valid && evt.ready)
			sb.check_event(evt.event_key, evt.event_kind, evt.last_of_run);
		if (hold_off_req > 0) begin
			hold_left    = hold_off_req;
			hold_off_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			evt.ready <= 1'b0;
		end else begin
			evt.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [KEY_CODE_W-1:0] key,
			logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.key_code  <= key;
		req.time_now  <= t;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_item(op, key, t);
		items_sent++;
	endtask

	// Stops offering items and waits until every predicted event has come out.
	task automatic drain_events();
		req.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic write_config(logic [CFG_W-1:0] short_ms, logic [CFG_W-1:0] long_ms,
			logic [CFG_W-1:0] hold_ms, logic [COMBO_KEY_W-1:0] key_a,
			logic [COMBO_KEY_W-1:0] key_b);
		put_reg(CFG_SHORT_MAX, short_ms);
		put_reg(CFG_LONG, long_ms);
		put_reg(CFG_COMBO_HOLD, hold_ms);
		put_reg(CFG_COMBO_A, {{(CFG_W-COMBO_KEY_W){1'b0}}, key_a});
		put_reg(CFG_COMBO_B, {{(CFG_W-COMBO_KEY_W){1'b0}}, key_b});
		cfg_we <= 1'b0;
	endtask

	// Random key activity. Time mostly moves in steps near the thresholds, with
	// an occasional large jump that also exercises the wrap of the difference.
	task automatic run_random(int count, int hold_at_item);
		logic [OP_W-1:0]       op;
		logic [KEY_CODE_W-1:0] key;
		int                    r;
		int                    kr;
		int                    done;
		done = 0;
		while (done < count) begin
			r  = $urandom_range(99);
			kr = $urandom_range(99);
			if (r < 4)
				op = OP_UNDEF;
			else if (r < 40)
				op = OP_PRESS;
			else if (r < 70)
				op = OP_RELEASE;
			else
				op = OP_TICK;
			if (kr < 12)
				key = KEY_CODE_W'($urandom_range(15, NUM_KEYS));
			else if (kr < 26)
				key = sb.combo_a;
			else if (kr < 40)
				key = sb.combo_b;
			else
				key = KEY_CODE_W'($urandom_range(NUM_KEYS - 1, 0));
			case ($urandom_range(31))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19:
					now_ms = now_ms + $urandom_range(step_max, 0);
				20, 21, 22, 23, 24, 25, 26, 27:
					now_ms = now_ms + $urandom_range(4 * step_max, 0);
				28, 29, 30:
					now_ms = now_ms + $urandom_range(140000, 0);
				default:
					now_ms = $urandom;
			endcase
			if (done == hold_at_item)
				hold_off_req = 400;
			send_item(op, key, now_ms);
			if (op != OP_UNDEF)
				done++;
		end
	endtask

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = '0;
		cfg_wdata      = '0;
		req.valid      = 1'b0;
		req.operation  = '0;
		req.key_code   = '0;
		req.time_now   = '0;
		evt.ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req   = 0;
		hold_left      = 0;
		items_sent     = 0;
		step_max       = 400;
		now_ms         = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		send_item(OP_PRESS, 4'd0, 32'd0);
		send_item(OP_RELEASE, 4'd0, 32'd299);
		send_item(OP_RELEASE, 4'd3, 32'd1400);
		send_item(OP_PRESS, 4'd15, 32'd1500);
		send_item(OP_RELEASE, 4'd8, 32'd1500);
		send_item(OP_UNDEF, 4'd15, 32'hFFFF_FFFF);
		send_item(OP_PRESS, 4'd5, 32'd2000);
		send_item(OP_TICK, 4'd0, 32'd2499);
		send_item(OP_TICK, 4'd9, 32'd2500);
		// A repeated press restarts the hold, so the release counts as short.
		send_item(OP_PRESS, 4'd5, 32'd3100);
		send_item(OP_RELEASE, 4'd5, 32'd3200);
		send_item(OP_PRESS, 4'd6, 32'hFFFF_FF00);
		send_item(OP_RELEASE, 4'd6, 32'h0000_0010);
		// All keys held: the second tick fires every long press and the combo.
		for (int k = 0; k < NUM_KEYS; k++)
			send_item(OP_PRESS, k[KEY_CODE_W-1:0], 32'h8000_0000);
		send_item(OP_TICK, 4'd0, 32'h8000_0001);
		send_item(OP_TICK, 4'd0, 32'h8000_0BB9);
		drain_events();

		// Full rate with a long receiver hold-off partway through.
		now_ms = $urandom;
		run_random(96, 30);
		drain_events();

		write_config(16'd50, 16'd120, 16'd400, 4'd2, 4'd3);
		send_idle_pct = 51;
		step_max      = 200;
		now_ms        = $urandom;
		run_random(96, -1);
		drain_events();

		// Zero thresholds, combo keys out of range.
		write_config(16'd0, 16'd0, 16'd0, 4'd15, 4'd15);
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		step_max       = 50;
		now_ms         = $urandom;
		run_random(96, -1);
		drain_events();

		// Largest thresholds, one key serving as both combo keys.
		write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd4, 4'd4);
		send_idle_pct  = 21;
		recv_stall_pct = 21;
		step_max       = 20000;
		now_ms         = $urandom;
		run_random(96, -1);
		drain_events();

		write_config(16'd200, 16'd300, 16'd0, 4'd7, 4'd1);
		send_idle_pct  = 10;
		recv_stall_pct = 30;
		step_max       = 300;
		now_ms         = $urandom;
		run_random(96, 50);
		drain_events();

		if (sb.pending() > 0)
			sb.report_mismatch($sformatf("%0d predicted events never came", sb.pending()));
		$display("Ran %0d items over five register settings and four idle patterns.",
			items_sent);
		$display("Checked %0d events: %0d long presses, %0d combo resets, %0d mismatches.",
			sb.checked, sb.n_long, sb.n_reset, sb.errors);
		if (sb.errors == 0)
			$display("PASS key_gesture_detector");
		else
			$display("FAIL key_gesture_detector");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/kgd_pkg.sv
hw/rtl/kgd_if.sv
hw/rtl/kgd_ctrl.sv
hw/rtl/kgd_dp.sv
hw/rtl/key_gesture_detector.sv
hw/rtl/kgd_checker.sv
dv/tb_key_gesture_detector.sv
